/* sv/idiv_pkg.sv */
// Package with the shared types of the 64-bit integer divider.
package idiv_pkg;

  // Division modes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_UNSIGNED    = 2'd0,
    FUNC_SIGNED      = 2'd1,
    FUNC_SIGNED_HALF = 2'd2
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  // Controls from the sequencer to the shared divide unit.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

/* sv/idiv_core.sv */
// Radix-2 restoring divide unit: one shift and subtract per cycle while step is set.
module idiv_core
  import idiv_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  div_ctrl_t             ctrl,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output logic [DATA_WIDTH-1:0] quo,
  output logic [DATA_WIDTH-1:0] rem
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] den_r;
  logic [W:0]   shifted;
  logic [W+1:0] diff;

  // Shift the next dividend bit into the partial remainder and trial-subtract.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctrl.step) begin
      if (!diff[W+1]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end
  end

  // The quotient register starts out holding the dividend magnitude.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

/* sv/integer_divider_64_top.sv */
// Top level of the integer divider: handshake, sign handling and sequencer.
//
//  Channel | Ports            | Contents
//  --------+------------------+-----------------------------------------------
//  input   | in_tvalid/tready | tdata: dividend [63:0], divisor [127:64]
//          |                  | tuser: func [1:0]
//  result  | out_tvalid/tready| tdata: quotient [63:0], remainder [127:64]
//          |                  | tuser: trap [0]
//
// Each word passes through the sequencer states in order: the idle state in which
// it is accepted, a state that takes magnitudes, DATA_WIDTH shift-subtract steps
// of the shared divide unit, one state of sign fixup, and the state of the result
// handshake. The result is held in an output register until taken; no new input
// word is accepted meanwhile, so an output stall also holds off the next input
// word. Reset is synchronous and returns the sequencer to idle.
module integer_divider_64_top
  import idiv_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // dividend [63:0], divisor [127:64]
  input  logic [1:0]   in_tuser,   // func [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // quotient [63:0], remainder [127:64]
  output logic         out_tuser   // trap [0]
);

  localparam int W  = DATA_WIDTH;
  localparam int H  = DATA_WIDTH / 2;
  localparam int CW = $clog2(DATA_WIDTH);

  state_t       state_r, state_nxt;
  div_ctrl_t    ctrl;
  logic [CW-1:0] cnt_r;

  func_t        func_r;
  logic [W-1:0] a_r, b_r;
  logic         neg_q_r, neg_r_r, zero_r, trap_r;

  logic         out_valid_r;
  logic [63:0]  out_quo_r, out_rem_r;
  logic         out_trap_r;

  logic [W-1:0] opa, opb, mag_a, mag_b;
  logic         is_half, is_signed, sa, sb, zero_div, trap_div;
  logic [W-1:0] core_quo, core_rem;
  logic [W-1:0] q_fix, r_fix;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_PREP:  ctrl.load = 1'b1;
      S_DIV:   ctrl.step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIX) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand selection: the half-width mode sign-extends the low halves.
  always_comb begin
    is_half   = (func_r == FUNC_SIGNED_HALF);
    is_signed = (func_r == FUNC_SIGNED) || is_half;
    opa = is_half ? {{(W-H){a_r[H-1]}}, a_r[H-1:0]} : a_r;
    opb = is_half ? {{(W-H){b_r[H-1]}}, b_r[H-1:0]} : b_r;
    sa  = is_signed && opa[W-1];
    sb  = is_signed && opb[W-1];
    mag_a = sa ? (~opa + 1'b1) : opa;
    mag_b = sb ? (~opb + 1'b1) : opb;
    zero_div = (opb == '0);
    trap_div = zero_div ||
               ((func_r == FUNC_SIGNED) && (opb == {1'b1, {(W-1){1'b0}}}));
  end

  // Input capture and per-word flags.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= func_t'(in_tuser);
      a_r    <= in_tdata[W-1:0];
      b_r    <= in_tdata[64 +: W];
    end
    if (state_r == S_PREP) begin
      neg_q_r <= sa ^ sb;
      neg_r_r <= sa;
      zero_r  <= zero_div;
      trap_r  <= trap_div;
      cnt_r   <= CW'(W - 1);
    end else if (state_r == S_DIV) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  idiv_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk (clk),
    .ctrl(ctrl),
    .num (mag_a),
    .den (mag_b),
    .quo (core_quo),
    .rem (core_rem)
  );

  // Sign fixup, half-width truncation and the zero-divisor override.
  always_comb begin
    q_fix = neg_q_r ? (~core_quo + 1'b1) : core_quo;
    r_fix = neg_r_r ? (~core_rem + 1'b1) : core_rem;
    if (is_half) begin
      q_fix = {{(W-H){q_fix[H-1]}}, q_fix[H-1:0]};
      r_fix = {{(W-H){r_fix[H-1]}}, r_fix[H-1:0]};
    end
    if (zero_r) begin
      q_fix = '0;
      r_fix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIX) begin
      out_quo_r  <= 64'(q_fix);
      out_rem_r  <= 64'(r_fix);
      out_trap_r <= trap_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rem_r, out_quo_r};
  assign out_tuser  = out_trap_r;

endmodule

/* tb/integer_divider_64_top_tb.sv */
// Self-checking testbench of the 64-bit integer divider: directed table, then random words.
module integer_divider_64_top_tb;
  import idiv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DATA_WIDTH     = 64;
  localparam int          NUM_DIR        = 25;
  localparam int          NUM_RANDOM     = 1300;
  localparam int          QUIET_FROM     = 1100;
  localparam int          HOLD_AT        = 300;
  localparam int          DRAIN_AT       = 650;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam logic [1:0]  FUNC_RESERVED  = 2'd3;
  localparam logic [63:0] SMIN           = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMAX           = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES           = 64'hFFFF_FFFF_FFFF_FFFF;

  // One result word: quotient, remainder and trap flag.
  typedef struct packed {
    logic [63:0] quot;
    logic [63:0] rem;
    logic        trap;
  } div_result_t;

  // One row of the directed table; the typed-in result is used when has_gold is set.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        has_gold;
    div_result_t gold;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // dividend [63:0], divisor [127:64]
  logic [1:0]   in_tuser;   // func [1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // quotient [63:0], remainder [127:64]
  logic         out_tuser;  // trap [0]

  div_result_t  quot_rem_q [$];
  int           errors;
  int           n_checked;
  int           n_words;
  int           n_traps;
  int           n_mode [4];
  bit           quiet;
  bit           hold_rx;

  // Directed words: zero divisors, wrap-around, most-negative divisors, reserved code.
  dir_row_t dir_tbl [NUM_DIR] = '{
    '{FUNC_UNSIGNED,    64'd0, 64'd0,                    1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_UNSIGNED,    ONES,  64'd0,                    1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_SIGNED,      SMIN,  64'd0,                    1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_SIGNED_HALF, 64'h0000_0000_8000_0000, 64'd0,  1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_SIGNED_HALF, 64'd5, 64'hFFFF_FFFF_0000_0000,  1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_UNSIGNED,    ONES,  64'd1,                    1'b1, '{ONES, 64'd0, 1'b0}},
    '{FUNC_UNSIGNED,    ONES,  ONES,                     1'b1, '{64'd1, 64'd0, 1'b0}},
    '{FUNC_UNSIGNED,    64'd0, ONES,                     1'b1, '{64'd0, 64'd0, 1'b0}},
    '{FUNC_UNSIGNED,    64'd1, ONES,                     1'b1, '{64'd0, 64'd1, 1'b0}},
    '{FUNC_UNSIGNED,    SMIN,  64'd2,                    1'b1,
      '{64'h4000_0000_0000_0000, 64'd0, 1'b0}},
    '{FUNC_SIGNED,      SMIN,  ONES,                     1'b1, '{SMIN, 64'd0, 1'b0}},
    '{FUNC_SIGNED,      SMIN,  SMIN,                     1'b1, '{64'd1, 64'd0, 1'b1}},
    '{FUNC_SIGNED,      64'd5, SMIN,                     1'b1, '{64'd0, 64'd5, 1'b1}},
    '{FUNC_SIGNED,      SMAX,  SMIN,                     1'b1, '{64'd0, SMAX, 1'b1}},
    '{FUNC_SIGNED,      ONES,  ONES,                     1'b1, '{64'd1, 64'd0, 1'b0}},
    '{FUNC_SIGNED,      64'hFFFF_FFFF_FFFF_FFF9, 64'd2,  1'b0, '0},
    '{FUNC_SIGNED,      64'd7, 64'hFFFF_FFFF_FFFF_FFFE,  1'b0, '0},
    '{FUNC_SIGNED,      SMAX,  64'd1,                    1'b1, '{SMAX, 64'd0, 1'b0}},
    '{FUNC_SIGNED_HALF, 64'hA5A5_A5A5_8000_0000, 64'h1234_5678_FFFF_FFFF, 1'b1,
      '{64'hFFFF_FFFF_8000_0000, 64'd0, 1'b0}},
    '{FUNC_SIGNED_HALF, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000, 1'b1,
      '{64'd1, 64'd0, 1'b0}},
    '{FUNC_SIGNED_HALF, 64'hFFFF_FFFF_FFFF_FF9C, 64'd7,  1'b0, '0},
    '{FUNC_SIGNED_HALF, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000, 1'b1,
      '{64'd0, 64'h0000_0000_7FFF_FFFF, 1'b0}},
    '{FUNC_RESERVED,    64'd100, 64'd7,                  1'b1, '{64'd14, 64'd2, 1'b0}},
    '{FUNC_RESERVED,    64'd5, 64'd0,                    1'b1, '{64'd0, 64'd0, 1'b1}},
    '{FUNC_UNSIGNED,    64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_0000, 1'b0, '0}
  };

  integer_divider_64_top #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // Truncating division in the selected mode; a zero divisor traps with zero results.
  function automatic div_result_t divide_word(logic [1:0] func, logic [63:0] a,
                                              logic [63:0] b);
    div_result_t res;
    logic [63:0] na, da, qm, rm;
    logic [31:0] hna, hda, hqm, hrm;
    logic        nneg, dneg;
    res = '0;
    case (func)
      FUNC_SIGNED: begin
        if (b == 64'd0) begin
          res.trap = 1'b1;
        end else begin
          res.trap = (b == SMIN);
          nneg     = a[63];
          dneg     = b[63];
          na       = nneg ? -a : a;
          da       = dneg ? -b : b;
          qm       = na / da;
          rm       = na % da;
          res.quot = (nneg != dneg) ? -qm : qm;
          res.rem  = nneg ? -rm : rm;
        end
      end
      FUNC_SIGNED_HALF: begin
        // Only the low halves count; results are sign-extended from 32 bits.
        if (b[31:0] == 32'd0) begin
          res.trap = 1'b1;
        end else begin
          nneg     = a[31];
          dneg     = b[31];
          hna      = nneg ? -a[31:0] : a[31:0];
          hda      = dneg ? -b[31:0] : b[31:0];
          hqm      = hna / hda;
          hrm      = hna % hda;
          hqm      = (nneg != dneg) ? -hqm : hqm;
          hrm      = nneg ? -hrm : hrm;
          res.quot = {{32{hqm[31]}}, hqm};
          res.rem  = {{32{hrm[31]}}, hrm};
        end
      end
      default: begin
        // Unsigned, which the reserved code also selects.
        if (b == 64'd0) begin
          res.trap = 1'b1;
        end else begin
          res.quot = a / b;
          res.rem  = a % b;
        end
      end
    endcase
    return res;
  endfunction

  // Operand patterns weighted towards the corners of both widths.
  function automatic logic [63:0] pick_operand();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 10))
      0, 1, 2: return {$urandom, $urandom};
      3:       return 64'($urandom_range(0, 15));
      4:       return 64'd1 << $urandom_range(0, 63);
      5:       return -(64'd1 << $urandom_range(0, 63));
      6: begin
        case ($urandom_range(0, 4))
          0:       return 64'd0;
          1:       return 64'd1;
          2:       return ONES;
          3:       return SMIN;
          default: return SMAX;
        endcase
      end
      7:       return {{32{w[31]}}, w};
      8:       return {$urandom, 32'($urandom_range(0, 15))};
      9: begin
        case ($urandom_range(0, 2))
          0:       return {$urandom, 32'h8000_0000};
          1:       return {$urandom, 32'hFFFF_FFFF};
          default: return {$urandom, 32'h7FFF_FFFF};
        endcase
      end
      default: return -64'($urandom_range(1, 15));
    endcase
  endfunction

  // Offers one word, after an optional idle burst, and returns once it is taken.
  task automatic offer_word(logic [1:0] func, logic [63:0] a, logic [63:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    n_words++;
    n_mode[func]++;
  endtask

  // Receiver readiness: random ready runs and stalls, plus one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
        if ($urandom_range(0, 1) == 0) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  end

  // Result checker: each accepted word against the oldest expected one.
  always @(posedge clk) begin : result_check
    div_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quot_rem_q.size() == 0) begin
        $display("%0t: unexpected result word q=%h r=%h trap=%b", $time,
                 out_tdata[63:0], out_tdata[127:64], out_tuser);
        errors++;
      end else begin
        want = quot_rem_q.pop_front();
        n_checked++;
        if (out_tuser) n_traps++;
        if (out_tdata[63:0] !== want.quot) begin
          $display("%0t: quotient expected %h actual %h", $time, want.quot, out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== want.rem) begin
          $display("%0t: remainder expected %h actual %h", $time, want.rem,
                   out_tdata[127:64]);
          errors++;
        end
        if (out_tuser !== want.trap) begin
          $display("%0t: trap expected %b actual %b", $time, want.trap, out_tuser);
          errors++;
        end
      end
    end
  end

  // Run limit, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random words, drain and verdict.
  initial begin : main_seq
    logic [1:0]  func;
    logic [63:0] a, b;
    int          sel;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_UNSIGNED;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (int i = 0; i < NUM_DIR; i++) begin
      offer_word(dir_tbl[i].func, dir_tbl[i].dividend, dir_tbl[i].divisor);
      if (dir_tbl[i].has_gold) begin
        quot_rem_q.push_back(dir_tbl[i].gold);
      end else begin
        quot_rem_q.push_back(divide_word(dir_tbl[i].func, dir_tbl[i].dividend,
                                         dir_tbl[i].divisor));
      end
    end

    // Random part; the last stretch runs without idling on either side.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == HOLD_AT) hold_rx = 1'b1;
      if (i == QUIET_FROM) quiet = 1'b1;
      if (i == DRAIN_AT) begin
        // Sender pause until every outstanding result has come back.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (quot_rem_q.size() != 0);
      end
      sel = $urandom_range(0, 15);
      if (sel < 5)       func = FUNC_UNSIGNED;
      else if (sel < 10) func = FUNC_SIGNED;
      else if (sel < 15) func = FUNC_SIGNED_HALF;
      else               func = FUNC_RESERVED;
      a = pick_operand();
      b = pick_operand();
      offer_word(func, a, b);
      quot_rem_q.push_back(divide_word(func, a, b));
    end
    in_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (quot_rem_q.size() != 0) @(posedge clk);
    repeat (DATA_WIDTH + 10) @(posedge clk);

    $display("Checked %0d results from %0d words, %0d of them trapping.", n_checked,
             n_words, n_traps);
    $display("Modes: %0d unsigned, %0d signed, %0d half-width signed, %0d reserved code.",
             n_mode[0], n_mode[1], n_mode[2], n_mode[3]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
